// ----- rtl/sflp_pkg.sv -----
package sflp_pkg;

   // operation codes
   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_LOOP    = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;
   localparam logic [1:0] OP_PLAY    = 2'd3;

   // configuration register indexes
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TRANSPOSE   = 1'd1;

   // fixed field widths
   localparam int FRAME_W  = 10;
   localparam int SAMPLE_W = 24;
   localparam int RATE_W   = 20;
   localparam int FACTOR_W = 16;

   localparam logic [FACTOR_W-1:0] FACTOR_ONE = 16'd4096;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'hFFFFFF;

   typedef struct packed {
      logic [1:0]                opcode;
      logic [8:0]                bin;
      logic [FRAME_W-1:0]        frame;
      logic [SAMPLE_W-1:0]       amp_in;
      logic [SAMPLE_W-1:0]       freq_in;
      logic [FRAME_W-1:0]        loop_start;
      logic [FRAME_W-1:0]        loop_end;
      logic signed [RATE_W-1:0]  rate;
      logic [FACTOR_W-1:0]       transpose_factor;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] amp_out;
      logic [SAMPLE_W-1:0] freq_out;
   } rsp_type;

   // loop settings of one bin, stored next to its phase
   typedef struct packed {
      logic [FRAME_W-1:0]        start_frame;
      logic [FRAME_W-1:0]        end_frame;
      logic signed [RATE_W-1:0]  rate;
      logic [FACTOR_W-1:0]       factor;
   } bin_loop_type;

endpackage

// ----- rtl/spectral_frame_loop_player.sv -----
// channel | ports                          | moves
// --------+--------------------------------+-----------------------------------
// req     | req_valid, req_stall, req_data | operation word in (write/loop/restart/play)
// rsp     | rsp_valid, rsp_stall, rsp_data | amplitude and frequency word out, play only
// csr     | csr_we, csr_index, csr_wdata   | frame_count and transpose_enable writes
//
// frame writes go straight into the frame store as the word is accepted; loop set and restart
// read the bin memory, then write it back. play steps: bin read, two frame store reads,
// lerp multiply, sum, transpose multiply, saturate, phase wrap, a fix step when the phase wraps, write back
// a next frame past the frame count, or a wrap of a loop length or more, waits on a
// bit-serial remainder pass over the bits of the widened phase
// after reset a clearing pass over all BINS entries initializes the bin memory; req stalls
// a result waiting on rsp_stall holds the last play step; the block goes on only once it leaves
module spectral_frame_loop_player #(
   parameter int BINS      = 512,
   parameter int FRAMES    = 1024,
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sflp_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sflp_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [sflp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sflp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import sflp_pkg::*;

   localparam int BW      = $clog2(BINS);
   localparam int FA_W    = $clog2(FRAMES);
   localparam int FS_DEPTH = FRAMES << BW;
   localparam int FS_AW   = FA_W + BW;
   localparam int PW      = FRAME_W + FRAC_BITS;
   localparam int PSW     = ((PW > RATE_W) ? PW : RATE_W) + 2;
   localparam int MW      = PSW;
   localparam int CW      = $clog2(MW + 1);
   localparam int LOOP_W  = $bits(bin_loop_type);
   localparam int ENT_W   = PW + LOOP_W;
   localparam int SW      = FRAC_BITS + SAMPLE_W + 2;
   localparam int FRAC_MIN = ((1 << FRAC_BITS) + 9999) / 10000;
   localparam int FI_W    = FRAME_W + 1;
   localparam logic [FI_W-1:0] FC_MAX = (FRAMES > 2047) ? 11'd2047 : FI_W'(FRAMES);
   localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_BIN  = 4'd1;
   localparam logic [3:0] S_I2   = 4'd2;
   localparam logic [3:0] S_RD1  = 4'd3;
   localparam logic [3:0] S_RD2  = 4'd4;
   localparam logic [3:0] S_SUM  = 4'd5;
   localparam logic [3:0] S_XP   = 4'd6;
   localparam logic [3:0] S_SAT  = 4'd7;
   localparam logic [3:0] S_WRAP = 4'd8;
   localparam logic [3:0] S_WMOD = 4'd9;
   localparam logic [3:0] S_WFIX = 4'd10;
   localparam logic [3:0] S_DONE = 4'd11;

   // memories
   logic [2*SAMPLE_W-1:0] fs_mem [FS_DEPTH];
   logic [ENT_W-1:0]      bin_mem [BINS];

   // control and datapath registers
   logic [3:0]              state_ff, state_in;
   logic                    clr_busy_ff;
   logic [BW-1:0]           clr_idx_ff;
   logic [FI_W-1:0]         frame_count_ff;
   logic                    transpose_en_ff;
   req_type                 req_ff;
   logic [ENT_W-1:0]        bin_rd_ff;
   logic [2*SAMPLE_W-1:0]   fs_rd_ff;
   logic                    fs_ok_ff;
   bin_loop_type            loop_ff;
   logic [FRAC_BITS-1:0]    frac_ff;
   logic                    small_ff;
   logic [FI_W-1:0]         i2_ff;
   logic signed [PSW-1:0]   p_ff;
   logic [PW-1:0]           lo_ff, hi_ff, len_ff;
   logic [SAMPLE_W-1:0]     a1_amp_ff, a1_freq_ff;
   logic signed [SW-1:0]    prod_amp_ff, prod_freq_ff;
   logic [SAMPLE_W-1:0]     amp_ff, freq_ff;
   logic [SAMPLE_W+FACTOR_W-1:0] xp_ff;
   logic                    above_ff;
   logic [PW-1:0]           ph_new_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   // remainder unit registers
   logic                    mod_busy_ff;
   logic [CW-1:0]           mod_cnt_ff;
   logic [MW-1:0]           mod_x_ff, mod_y_ff, mod_r_ff;

   // combinational signals
   logic                    req_acc, bin_ok, frame_ok, out_free;
   logic                    fs_we, fs_re, fs_re_ok;
   logic [FS_AW-1:0]        fs_waddr, fs_raddr;
   logic                    bin_we;
   logic [BW-1:0]           bin_waddr;
   logic [ENT_W-1:0]        bin_wdata;
   logic [PW-1:0]           cur_ph;
   bin_loop_type            cur_loop, new_loop;
   logic [FRAME_W-1:0]      i1_raw, i1;
   logic [FI_W-1:0]         nxt, fc_eff;
   logic signed [PSW-1:0]   p_calc;
   logic [PW-1:0]           lo_calc, hi_calc;
   logic [2*SAMPLE_W-1:0]   fs_val;
   logic signed [SAMPLE_W:0] d_amp, d_freq;
   logic signed [FRAC_BITS:0] frac_s;
   logic signed [SW-1:0]    sum_amp, sum_freq;
   logic [SAMPLE_W+FACTOR_W:0] xr;
   logic                    p_above, p_below;
   logic [PSW-1:0]          wrap_gap;
   logic                    mod_start;
   logic [MW-1:0]           mod_x_in, mod_y_in;
   logic [MW:0]             mod_t;
   logic [MW-1:0]           mod_r_in;

   // handshakes
   assign req_stall = (state_ff != S_IDLE) || clr_busy_ff;
   assign req_acc   = req_valid && !req_stall;
   assign bin_ok    = 32'(req_data.bin) < BINS;
   assign frame_ok  = 32'(req_data.frame) < FRAMES;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // bin entry fields
   assign cur_ph   = bin_rd_ff[ENT_W-1 -: PW];
   assign cur_loop = bin_loop_type'(bin_rd_ff[LOOP_W-1:0]);

   // clamp integer phase into loop, next frame index
   assign i1_raw = cur_ph[PW-1:FRAC_BITS];
   assign i1     = (i1_raw < cur_loop.start_frame) ? cur_loop.start_frame :
                   (i1_raw > cur_loop.end_frame) ? cur_loop.end_frame : i1_raw;
   assign nxt    = FI_W'(i1) + FI_W'(1);
   assign fc_eff = (frame_count_ff == '0) ? FI_W'(1) :
                   (frame_count_ff > FC_MAX) ? FC_MAX : frame_count_ff;

   // advanced phase and loop bounds
   assign p_calc  = $signed({{(PSW-PW){1'b0}}, cur_ph})
                  + $signed({{(PSW-RATE_W){cur_loop.rate[RATE_W-1]}}, cur_loop.rate});
   assign lo_calc = {cur_loop.start_frame, {FRAC_BITS{1'b0}}};
   assign hi_calc = {cur_loop.end_frame, {FRAC_BITS{1'b0}}};

   // new loop settings from a loop set word
   always_comb begin
      new_loop.start_frame = req_ff.loop_start;
      new_loop.end_frame   = (req_ff.loop_end < req_ff.loop_start) ?
                             req_ff.loop_start : req_ff.loop_end;
      new_loop.rate        = req_ff.rate;
      new_loop.factor      = req_ff.transpose_factor;
   end

   // frame store read data, zero beyond the store
   assign fs_val = fs_ok_ff ? fs_rd_ff : '0;

   // lerp: a1 + (a2 - a1) * f, rounded half up
   assign frac_s  = $signed({1'b0, frac_ff});
   assign d_amp   = $signed({1'b0, fs_val[2*SAMPLE_W-1:SAMPLE_W]}) - $signed({1'b0, a1_amp_ff});
   assign d_freq  = $signed({1'b0, fs_val[SAMPLE_W-1:0]}) - $signed({1'b0, a1_freq_ff});
   assign sum_amp  = $signed({2'b00, a1_amp_ff, {FRAC_BITS{1'b0}}}) + prod_amp_ff + HALF;
   assign sum_freq = $signed({2'b00, a1_freq_ff, {FRAC_BITS{1'b0}}}) + prod_freq_ff + HALF;

   // transposition rounding
   assign xr = {1'b0, xp_ff} + (SAMPLE_W+FACTOR_W+1)'(2048);

   // wrap distance
   assign p_above  = p_ff > $signed({{(PSW-PW){1'b0}}, hi_ff});
   assign p_below  = p_ff < $signed({{(PSW-PW){1'b0}}, lo_ff});
   assign wrap_gap = p_above ? PSW'(p_ff - $signed({{(PSW-PW){1'b0}}, hi_ff}))
                             : PSW'($signed({{(PSW-PW){1'b0}}, lo_ff}) - p_ff);

   // remainder unit step
   assign mod_t    = {mod_r_ff, mod_x_ff[MW-1]};
   assign mod_r_in = (mod_t >= {1'b0, mod_y_ff}) ? MW'(mod_t - {1'b0, mod_y_ff}) : mod_t[MW-1:0];

   // sequencer
   always_comb begin
      state_in  = state_ff;
      fs_we     = 1'b0;
      fs_waddr  = {FA_W'(req_data.frame), BW'(req_data.bin)};
      fs_re     = 1'b0;
      fs_raddr  = {FA_W'(i1), BW'(req_ff.bin)};
      fs_re_ok  = 32'(i1) < FRAMES;
      bin_we    = 1'b0;
      bin_waddr = BW'(req_ff.bin);
      bin_wdata = {ph_new_ff, loop_ff};
      mod_start = 1'b0;
      mod_x_in  = MW'(nxt);
      mod_y_in  = MW'(fc_eff);
      case (state_ff)
         S_IDLE: begin
            if (req_acc && bin_ok) begin
               if (req_data.opcode == OP_WRITE) begin
                  fs_we = frame_ok;
               end else begin
                  state_in = S_BIN;
               end
            end
         end
         S_BIN: begin
            case (req_ff.opcode)
               OP_LOOP: begin
                  bin_we    = 1'b1;
                  bin_wdata = {cur_ph, new_loop};
                  state_in  = S_IDLE;
               end
               OP_RESTART: begin
                  bin_we    = 1'b1;
                  bin_wdata = {lo_calc, cur_loop};
                  state_in  = S_IDLE;
               end
               OP_PLAY: begin
                  fs_re = 1'b1;
                  if (nxt <= fc_eff) begin
                     state_in = S_RD1;
                  end else begin
                     mod_start = 1'b1;
                     state_in  = S_I2;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_I2: begin
            if (!mod_busy_ff) begin
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            fs_re    = 1'b1;
            fs_raddr = {FA_W'(i2_ff), BW'(req_ff.bin)};
            fs_re_ok = 32'(i2_ff) < FRAMES;
            state_in = S_RD2;
         end
         S_RD2: state_in = S_SUM;
         S_SUM: state_in = S_XP;
         S_XP:  state_in = S_SAT;
         S_SAT: state_in = S_WRAP;
         S_WRAP: begin
            if (len_ff == '0 || (!p_above && !p_below)) begin
               state_in = S_DONE;
            end else if (wrap_gap < PSW'(len_ff)) begin
               state_in = S_WFIX;
            end else begin
               mod_start = 1'b1;
               mod_x_in  = MW'(wrap_gap);
               mod_y_in  = MW'(len_ff);
               state_in  = S_WMOD;
            end
         end
         S_WMOD: begin
            if (!mod_busy_ff) begin
               state_in = S_WFIX;
            end
         end
         S_WFIX: state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               bin_we   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // clearing pass overrides the bin write port
      if (clr_busy_ff) begin
         bin_we    = 1'b1;
         bin_waddr = clr_idx_ff;
         bin_wdata = {{PW{1'b0}}, FRAME_W'(0), FRAME_W'(0), RATE_W'(0), FACTOR_ONE};
      end
   end

   // frame store
   always_ff @(posedge clock) begin
      if (fs_we) begin
         fs_mem[fs_waddr] <= {req_data.amp_in, req_data.freq_in};
      end
      if (fs_re) begin
         fs_rd_ff <= fs_mem[fs_raddr];
         fs_ok_ff <= fs_re_ok;
      end
   end

   // bin memory
   always_ff @(posedge clock) begin
      if (bin_we) begin
         bin_mem[bin_waddr] <= bin_wdata;
      end
      if (req_acc) begin
         bin_rd_ff <= bin_mem[BW'(req_data.bin)];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         clr_busy_ff     <= 1'b1;
         clr_idx_ff      <= '0;
         frame_count_ff  <= FI_W'(1024);
         transpose_en_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clr_busy_ff) begin
            if (32'(clr_idx_ff) == BINS - 1) begin
               clr_busy_ff <= 1'b0;
            end else begin
               clr_idx_ff <= clr_idx_ff + BW'(1);
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_FRAME_COUNT: frame_count_ff <= csr_wdata;
               REG_TRANSPOSE:   transpose_en_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // remainder unit, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_busy_ff <= 1'b0;
         mod_cnt_ff  <= '0;
      end else if (mod_start) begin
         mod_busy_ff <= 1'b1;
         mod_cnt_ff  <= '0;
         mod_x_ff    <= mod_x_in;
         mod_y_ff    <= mod_y_in;
         mod_r_ff    <= '0;
      end else if (mod_busy_ff) begin
         mod_r_ff <= mod_r_in;
         mod_x_ff <= {mod_x_ff[MW-2:0], 1'b0};
         mod_cnt_ff <= mod_cnt_ff + CW'(1);
         if (32'(mod_cnt_ff) == MW - 1) begin
            mod_busy_ff <= 1'b0;
         end
      end
   end

   // play datapath
   always_ff @(posedge clock) begin
      if (req_acc) begin
         req_ff <= req_data;
      end
      case (state_ff)
         S_BIN: begin
            loop_ff  <= cur_loop;
            frac_ff  <= cur_ph[FRAC_BITS-1:0];
            small_ff <= 32'(cur_ph[FRAC_BITS-1:0]) < FRAC_MIN;
            i2_ff    <= (nxt == fc_eff) ? '0 : nxt;
            p_ff     <= p_calc;
            lo_ff    <= lo_calc;
            hi_ff    <= hi_calc;
            len_ff   <= hi_calc - lo_calc;
         end
         S_I2: begin
            if (!mod_busy_ff) begin
               i2_ff <= FI_W'(mod_r_ff);
            end
         end
         S_RD1: begin
            a1_amp_ff  <= fs_val[2*SAMPLE_W-1:SAMPLE_W];
            a1_freq_ff <= fs_val[SAMPLE_W-1:0];
         end
         S_RD2: begin
            prod_amp_ff  <= SW'(d_amp * frac_s);
            prod_freq_ff <= SW'(d_freq * frac_s);
         end
         S_SUM: begin
            amp_ff  <= small_ff ? a1_amp_ff : sum_amp[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
            freq_ff <= small_ff ? a1_freq_ff : sum_freq[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
         end
         S_XP: begin
            xp_ff <= freq_ff * loop_ff.factor;
         end
         S_SAT: begin
            if (transpose_en_ff) begin
               freq_ff <= (xr[SAMPLE_W+FACTOR_W:12] > (SAMPLE_W+FACTOR_W-11)'(SAMPLE_MAX)) ?
                          SAMPLE_MAX : xr[SAMPLE_W+11:12];
            end
         end
         S_WRAP: begin
            above_ff <= p_above;
         end
         default: ;
      endcase
   end

   // wrapped phase
   always_ff @(posedge clock) begin
      case (state_ff)
         S_WRAP: begin
            if (len_ff == '0) begin
               ph_new_ff <= lo_ff;
            end else if (!p_above && !p_below) begin
               ph_new_ff <= p_ff[PW-1:0];
            end else begin
               ph_new_ff <= PW'(wrap_gap);
            end
         end
         S_WMOD: begin
            if (!mod_busy_ff) begin
               ph_new_ff <= PW'(mod_r_ff);
            end
         end
         S_WFIX: begin
            if (ph_new_ff == '0) begin
               ph_new_ff <= above_ff ? hi_ff : lo_ff;
            end else begin
               ph_new_ff <= above_ff ? lo_ff + ph_new_ff : hi_ff - ph_new_ff;
            end
         end
         default: ;
      endcase
   end

   // result word
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && out_free) begin
         rsp_ff.amp_out  <= amp_ff;
         rsp_ff.freq_out <= freq_ff;
      end
   end

   // no item is taken during the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> req_stall)
      else $error("item accepted during bin clearing pass");

   // the remainder unit only runs while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      mod_busy_ff |-> (state_ff == S_I2 || state_ff == S_WMOD))
      else $error("remainder unit busy outside its wait states");

   // a written back phase lies inside its loop
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |-> (ph_new_ff >= lo_ff && ph_new_ff <= hi_ff))
      else $error("wrapped phase outside loop");

   // the next frame index stays below the frame count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD1) |-> (i2_ff < fc_eff))
      else $error("next frame index not wrapped");

endmodule
